// ----- rtl/p2db_pkg.sv -----
// Package for the pixel to display bytes block: pixel type and layout codes,
// shared types and the per-component normalization functions.
// No dependencies.
`default_nettype none
package p2db_pkg;

    localparam logic [3:0] PT_U8      = 4'd0;
    localparam logic [3:0] PT_S8      = 4'd1;
    localparam logic [3:0] PT_U16     = 4'd2;
    localparam logic [3:0] PT_S16     = 4'd3;
    localparam logic [3:0] PT_U32     = 4'd4;
    localparam logic [3:0] PT_S32     = 4'd5;
    localparam logic [3:0] PT_F32     = 4'd6;
    localparam logic [3:0] PT_4444    = 4'd7;
    localparam logic [3:0] PT_5551    = 4'd8;
    localparam logic [3:0] PT_2101010 = 4'd9;
    localparam logic [3:0] PT_565     = 4'd10;
    localparam logic [3:0] PT_24_8    = 4'd11;
    localparam logic [3:0] PT_F32_S8  = 4'd12;

    localparam logic [2:0] LY_RED  = 3'd0;
    localparam logic [2:0] LY_RG   = 3'd1;
    localparam logic [2:0] LY_RGB  = 3'd2;
    localparam logic [2:0] LY_RGBA = 3'd3;
    localparam logic [2:0] LY_DEP  = 3'd4;
    localparam logic [2:0] LY_DS   = 3'd5;

    localparam logic [2:0] CNT_BGRA = 3'd4;
    localparam logic [2:0] CNT_RGBX = 3'd3;
    localparam logic [2:0] CNT_MONO = 3'd1;

    localparam int NUM_LANES = 4;

    typedef struct packed {
        logic [3:0] ptype;
        logic [2:0] layout;
    } p2db_cfg_t;

    // floor(x*255/(2^n-1)): estimate by (p + (p>>n) + 1) >> n, which is
    // within one of the true quotient, then step it by one either way.
    function automatic logic [7:0] unorm_n(input logic [31:0] x, input int n);
        logic [40:0] m;
        logic [40:0] p;
        logic [40:0] t;
        logic [40:0] q;
        begin
            m = (41'd1 << n) - 41'd1;
            p = {9'd0, x} * 41'd255;
            t = p + (p >> n) + 41'd1;
            q = t >> n;
            if (q * m > p)
                q = q - 41'd1;
            else if ((q + 41'd1) * m <= p)
                q = q + 41'd1;
            unorm_n = q[7:0];
        end
    endfunction

    function automatic logic [7:0] snorm_n(input logic [31:0] x, input int n);
        logic [31:0] v;
        logic [7:0]  q;
        begin
            v = x & ((32'd1 << (n - 1)) - 32'd1);
            if (x[n-1] || v == 32'd0)
                snorm_n = 8'd0;
            else if (v == ((32'd1 << (n - 1)) - 32'd1))
                snorm_n = 8'd255;
            else
            begin
                q = unorm_n(v, n - 1);
                snorm_n = q;
            end
        end
    endfunction

    function automatic logic [7:0] f32_byte(input logic [31:0] b);
        logic [7:0]  ex;
        logic [22:0] fr;
        logic [31:0] m;
        logic [7:0]  sh;
        logic [31:0] r;
        begin
            ex = b[30:23];
            fr = b[22:0];
            m  = {8'd0, 1'b1, fr} * 32'd255;
            sh = 8'd150 - ex;
            r  = m >> sh[5:0];
            if (ex == 8'hff && fr != 23'd0)
                f32_byte = 8'd255;
            else if (b[31])
                f32_byte = 8'd0;
            else if (ex >= 8'd127)
                f32_byte = 8'd255;
            else if (ex == 8'd0 || sh >= 8'd32)
                f32_byte = 8'd0;
            else
                f32_byte = r[7:0];
        end
    endfunction

endpackage
`default_nettype wire

// ----- rtl/p2db_lane.sv -----
// One conversion lane: turns one component word into one normalized byte.
// Depends on p2db_pkg.
`default_nettype none
module p2db_lane
    import p2db_pkg::*;
(
    input  wire logic [3:0]  ptype,
    input  wire logic [31:0] word,
    output logic      [7:0]  cbyte
);

    always_comb
    begin
        case (ptype)
            PT_S8:   cbyte = snorm_n(word & 32'hff, 8);
            PT_U16:  cbyte = unorm_n(word & 32'hffff, 16);
            PT_S16:  cbyte = snorm_n(word & 32'hffff, 16);
            PT_U32:  cbyte = unorm_n(word, 32);
            PT_S32:  cbyte = snorm_n(word, 32);
            PT_F32:  cbyte = f32_byte(word);
            default: cbyte = word[7:0];
        endcase
    end

endmodule
`default_nettype wire

// ----- rtl/p2db_merge.sv -----
// Merge stage: decodes packed formats, picks lane results, orders bytes.
// Depends on p2db_pkg.
`default_nettype none
module p2db_merge
    import p2db_pkg::*;
(
    input  wire p2db_cfg_t   cfg,
    input  wire logic [31:0] word_a,
    input  wire logic [31:0] word_b,
    input  wire logic [7:0]  lane0,
    input  wire logic [7:0]  lane1,
    input  wire logic [7:0]  lane2,
    input  wire logic [7:0]  lane3,
    output logic      [7:0]  b0,
    output logic      [7:0]  b1,
    output logic      [7:0]  b2,
    output logic      [7:0]  b3,
    output logic      [2:0]  cnt
);

    logic [2:0] ly;
    logic [2:0] ncomp;
    logic [7:0] c0, c1, c2, c3;

    always_comb
    begin
        ly = (cfg.layout > LY_DS) ? LY_RED : cfg.layout;
        case (ly)
            LY_RED, LY_DEP: ncomp = 3'd1;
            LY_RG, LY_DS:   ncomp = 3'd2;
            LY_RGB:         ncomp = 3'd3;
            default:        ncomp = 3'd4;
        endcase
        c0 = 8'd0;
        c1 = 8'd0;
        c2 = 8'd0;
        c3 = 8'd255;
        case (cfg.ptype)
            PT_4444:
            begin
                c0 = {word_a[15:12], word_a[15:12]};
                c1 = {word_a[11:8], word_a[11:8]};
                c2 = {word_a[7:4], word_a[7:4]};
                c3 = {word_a[3:0], word_a[3:0]};
            end
            PT_5551:
            begin
                c0 = unorm_n({27'd0, word_a[15:11]}, 5);
                c1 = unorm_n({27'd0, word_a[10:6]}, 5);
                c2 = unorm_n({27'd0, word_a[5:1]}, 5);
                c3 = word_a[0] ? 8'd255 : 8'd0;
            end
            PT_2101010:
            begin
                c0 = unorm_n({22'd0, word_a[9:0]}, 10);
                c1 = unorm_n({22'd0, word_a[19:10]}, 10);
                c2 = unorm_n({22'd0, word_a[29:20]}, 10);
                c3 = 8'(word_a[31:30] * 8'd85);
            end
            PT_565:
            begin
                c0 = unorm_n({27'd0, word_a[15:11]}, 5);
                c1 = unorm_n({26'd0, word_a[10:5]}, 6);
                c2 = unorm_n({27'd0, word_a[4:0]}, 5);
            end
            PT_24_8:
            begin
                c0 = unorm_n({8'd0, word_a[31:8]}, 24);
                c1 = word_a[7:0];
            end
            PT_F32_S8:
            begin
                c0 = f32_byte(word_a);
                c1 = word_b[7:0];
            end
            default:
            begin
                c0 = lane0;
                if (ncomp >= 3'd2)
                    c1 = lane1;
                if (ncomp >= 3'd3)
                    c2 = lane2;
                if (ncomp >= 3'd4)
                    c3 = lane3;
            end
        endcase
        case (ly)
            LY_RGBA:
            begin
                b0 = c2; b1 = c1; b2 = c0; b3 = c3; cnt = CNT_BGRA;
            end
            LY_DEP:
            begin
                b0 = c0; b1 = 8'd0; b2 = 8'd0; b3 = 8'd0; cnt = CNT_MONO;
            end
            default:
            begin
                b0 = c0; b1 = c1; b2 = c2; b3 = 8'd0; cnt = CNT_RGBX;
            end
        endcase
    end

endmodule
`default_nettype wire

// ----- rtl/pixel_to_display_bytes_top.sv -----
// Top level of the pixel to display bytes converter: config registers,
// input stage, four conversion lanes, merge and output register.
// Depends on p2db_pkg, p2db_lane, p2db_merge.
//
// Usage: write pixel_type (index 0) and channel_layout (index 1) through
// cfg_we/cfg_index/cfg_data while idle. Requests enter on in_valid and are
// taken when in_stall is low; results leave on out_valid with out_stall.
// Two register stages: an input register feeding the four lanes and the
// merge, then an output register. out_valid rises once a taken request has
// moved from the input register into the output register; throughput is
// one pixel per cycle while the output is not stalled, set by the single lane
// and merge stage between the two registers. in_stall is raised only when
// both stages are full and the output is stalled, so a stall propagates
// back one stage at a time and no request is lost or repeated.
// Reset clears both valid bits and loads pixel_type 0, channel_layout 3.
`default_nettype none
module pixel_to_display_bytes_top
    import p2db_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [0:0]  cfg_index,
    input  wire logic [3:0]  cfg_data,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [31:0] word_a,
    input  wire logic [31:0] word_b,
    input  wire logic [31:0] word_c,
    input  wire logic [31:0] word_d,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic      [7:0]  out_byte0,
    output logic      [7:0]  out_byte1,
    output logic      [7:0]  out_byte2,
    output logic      [7:0]  out_byte3,
    output logic      [2:0]  byte_count
);

    p2db_cfg_t   cfg_reg;
    logic        s1_valid_reg;
    logic [31:0] w_reg [NUM_LANES];
    logic [7:0]  lane_byte [NUM_LANES];
    logic [7:0]  m0, m1, m2, m3;
    logic [2:0]  mcnt;
    logic        s1_adv, s2_load;

    assign s2_load  = s1_valid_reg && (!out_valid || !out_stall);
    assign in_stall = s1_valid_reg && !s2_load;
    assign s1_adv   = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg      <= '{ptype: PT_U8, layout: LY_RGBA};
            s1_valid_reg <= 1'b0;
            out_valid    <= 1'b0;
        end
        else
        begin
            if (cfg_we && cfg_index == 1'b0)
                cfg_reg.ptype <= cfg_data;
            else if (cfg_we)
                cfg_reg.layout <= cfg_data[2:0];
            if (s1_adv)
                s1_valid_reg <= 1'b1;
            else if (s2_load)
                s1_valid_reg <= 1'b0;
            if (s2_load)
                out_valid <= 1'b1;
            else if (!out_stall)
                out_valid <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            w_reg[0] <= word_a;
            w_reg[1] <= word_b;
            w_reg[2] <= word_c;
            w_reg[3] <= word_d;
        end
        if (s2_load)
        begin
            out_byte0  <= m0;
            out_byte1  <= m1;
            out_byte2  <= m2;
            out_byte3  <= m3;
            byte_count <= mcnt;
        end
    end

    for (genvar g = 0; g < NUM_LANES; g++)
    begin : g_lane
        p2db_lane u_lane (
            .ptype (cfg_reg.ptype),
            .word  (w_reg[g]),
            .cbyte (lane_byte[g])
        );
    end

    p2db_merge u_merge (
        .cfg    (cfg_reg),
        .word_a (w_reg[0]),
        .word_b (w_reg[1]),
        .lane0  (lane_byte[0]),
        .lane1  (lane_byte[1]),
        .lane2  (lane_byte[2]),
        .lane3  (lane_byte[3]),
        .b0     (m0),
        .b1     (m1),
        .b2     (m2),
        .b3     (m3),
        .cnt    (mcnt)
    );

endmodule
`default_nettype wire

// ----- tb/sv/tb_top.sv -----
// Self-checking testbench for pixel_to_display_bytes_top: a directed table of
// pixels and random pixels over many type/layout settings, with results checked
// against table values or an in-file conversion predictor. Depends on p2db_pkg and the RTL.
`default_nettype none
module tb_top;
    import p2db_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        logic [7:0] b3;
        logic [2:0] cnt;
    } lanes_t;

    typedef struct packed {
        logic [3:0]  ptype;
        logic [2:0]  layout;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [31:0] d;
        logic        fixed;
        lanes_t      want;
    } pixel_row_t;

    localparam int NUM_ROWS = 22;
    localparam lanes_t NO_LANES = '{8'd0, 8'd0, 8'd0, 8'd0, 3'd0};

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [0:0]  cfg_index;
    logic [3:0]  cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic [31:0] word_a;
    logic [31:0] word_b;
    logic [31:0] word_c;
    logic [31:0] word_d;
    logic        out_valid;
    logic        out_stall;
    logic [7:0]  out_byte0;
    logic [7:0]  out_byte1;
    logic [7:0]  out_byte2;
    logic [7:0]  out_byte3;
    logic [2:0]  byte_count;

    lanes_t      pending_bytes[$];
    int          errors;
    logic [3:0]  cur_ptype;
    logic [2:0]  cur_layout;
    bit          quiet;
    bit          hold_req;

    pixel_row_t  pixel_rows[NUM_ROWS] = '{
        '{PT_U8, LY_RGBA, 32'hffffff12, 32'h34, 32'h56, 32'h789, 1'b1,
          '{8'h56, 8'h34, 8'h12, 8'h89, CNT_BGRA}},
        '{PT_U8, LY_RED, 32'hff, 32'hffffffff, 32'hffffffff, 32'hffffffff, 1'b1,
          '{8'hff, 8'h00, 8'h00, 8'h00, CNT_RGBX}},
        '{PT_S8, LY_RGBA, 32'h7f, 32'h80, 32'h0, 32'h1, 1'b1,
          '{8'h00, 8'h00, 8'hff, 8'h02, CNT_BGRA}},
        '{PT_U16, LY_RG, 32'hffff, 32'h0, 32'hffff, 32'hffff, 1'b1,
          '{8'hff, 8'h00, 8'h00, 8'h00, CNT_RGBX}},
        '{PT_S16, LY_RGB, 32'h7fff, 32'h8000, 32'h4000, 32'h0, 1'b0, NO_LANES},
        '{PT_U32, LY_RGBA, 32'hffffffff, 32'h0, 32'h80000000, 32'h1, 1'b0, NO_LANES},
        '{PT_S32, LY_DEP, 32'h7fffffff, 32'h0, 32'h0, 32'h0, 1'b1,
          '{8'hff, 8'h00, 8'h00, 8'h00, CNT_MONO}},
        '{PT_S32, LY_RED, 32'h80000000, 32'h0, 32'h0, 32'h0, 1'b1,
          '{8'h00, 8'h00, 8'h00, 8'h00, CNT_RGBX}},
        '{PT_F32, LY_RGBA, 32'h3f800000, 32'h7fc00000, 32'hff800001, 32'h80000000,
          1'b1, '{8'hff, 8'hff, 8'hff, 8'h00, CNT_BGRA}},
        '{PT_F32, LY_RGB, 32'h3f000000, 32'h00000001, 32'h7f800000, 32'h0, 1'b0,
          NO_LANES},
        '{PT_F32, LY_DEP, 32'h3effffff, 32'h0, 32'h0, 32'h0, 1'b0, NO_LANES},
        '{PT_F32, LY_RG, 32'hff800000, 32'h33800000, 32'h0, 32'h0, 1'b0, NO_LANES},
        '{PT_4444, LY_RGB, 32'h1234, 32'h0, 32'h0, 32'h0, 1'b0, NO_LANES},
        '{PT_4444, LY_RGBA, 32'hffff0f0f, 32'h0, 32'h0, 32'h0, 1'b0, NO_LANES},
        '{PT_5551, LY_RGBA, 32'hffff, 32'h0, 32'h0, 32'h0, 1'b0, NO_LANES},
        '{PT_5551, LY_RED, 32'hfffe, 32'h0, 32'h0, 32'h0, 1'b0, NO_LANES},
        '{PT_2101010, LY_RGBA, 32'hffffffff, 32'h0, 32'h0, 32'h0, 1'b1,
          '{8'hff, 8'hff, 8'hff, 8'hff, CNT_BGRA}},
        '{PT_565, LY_RGB, 32'hffff, 32'h0, 32'h0, 32'h0, 1'b1,
          '{8'hff, 8'hff, 8'hff, 8'h00, CNT_RGBX}},
        '{PT_565, LY_RGBA, 32'h8410, 32'h0, 32'h0, 32'h0, 1'b0, NO_LANES},
        '{PT_24_8, LY_DS, 32'hffffff55, 32'h0, 32'h0, 32'h0, 1'b1,
          '{8'hff, 8'h55, 8'h00, 8'h00, CNT_RGBX}},
        '{PT_F32_S8, LY_DS, 32'h3f800000, 32'h1ab, 32'h0, 32'h0, 1'b1,
          '{8'hff, 8'hab, 8'h00, 8'h00, CNT_RGBX}},
        '{4'd15, 3'd7, 32'h12345678, 32'h9abcdef0, 32'h0, 32'h0, 1'b0, NO_LANES}
    };

    pixel_to_display_bytes_top u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .word_a     (word_a),
        .word_b     (word_b),
        .word_c     (word_c),
        .word_d     (word_d),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_byte0  (out_byte0),
        .out_byte1  (out_byte1),
        .out_byte2  (out_byte2),
        .out_byte3  (out_byte3),
        .byte_count (byte_count)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    function automatic logic [7:0] unorm_to_byte(longint unsigned x, longint unsigned mx);
        return 8'((x * 255) / mx);
    endfunction

    function automatic logic [7:0] snorm_to_byte(longint unsigned raw, int bits,
                                                 longint unsigned mx);
        longint unsigned q;
        if (raw[bits-1] || raw == 0)
            return 8'd0;
        q = (raw * 255) / mx;
        return (q > 255) ? 8'd255 : 8'(q);
    endfunction

    function automatic logic [7:0] float_to_byte(logic [31:0] f);
        int unsigned     shift;
        longint unsigned m;
        if (f[30:23] == 8'hff && f[22:0] != 0)
            return 8'd255;
        if (f[31])
            return 8'd0;
        if (f[30:23] >= 8'd127)
            return 8'd255;
        if (f[30:23] == 8'd0)
            return 8'd0;
        shift = 150 - f[30:23];
        if (shift >= 40)
            return 8'd0;
        m = longint'({1'b1, f[22:0]}) * 255;
        return 8'(m >> shift);
    endfunction

    function automatic logic [7:0] comp_to_byte(logic [3:0] pt, logic [31:0] w);
        case (pt)
            PT_S8:   return snorm_to_byte(w[7:0], 8, 127);
            PT_U16:  return unorm_to_byte(w[15:0], 65535);
            PT_S16:  return snorm_to_byte(w[15:0], 16, 32767);
            PT_U32:  return unorm_to_byte(w, 64'd4294967295);
            PT_S32:  return snorm_to_byte(w, 32, 64'd2147483647);
            PT_F32:  return float_to_byte(w);
            default: return w[7:0];
        endcase
    endfunction

    function automatic lanes_t convert_pixel(logic [3:0] pt, logic [2:0] lay_in,
                                             logic [31:0] a, logic [31:0] b,
                                             logic [31:0] c, logic [31:0] d);
        logic [7:0]  comp[4];
        logic [31:0] w[4];
        logic [2:0]  lay;
        int          ncomp;
        lanes_t      r;
        w = '{a, b, c, d};
        comp = '{8'd0, 8'd0, 8'd0, 8'd255};
        lay = (lay_in > LY_DS) ? LY_RED : lay_in;
        ncomp = (lay == LY_RED || lay == LY_DEP) ? 1 :
                (lay == LY_RG || lay == LY_DS) ? 2 : (lay == LY_RGB) ? 3 : 4;
        case (pt)
            PT_4444:
            begin
                comp[0] = 8'(a[15:12] * 17);
                comp[1] = 8'(a[11:8] * 17);
                comp[2] = 8'(a[7:4] * 17);
                comp[3] = 8'(a[3:0] * 17);
            end
            PT_5551:
            begin
                comp[0] = unorm_to_byte(a[15:11], 31);
                comp[1] = unorm_to_byte(a[10:6], 31);
                comp[2] = unorm_to_byte(a[5:1], 31);
                comp[3] = a[0] ? 8'd255 : 8'd0;
            end
            PT_2101010:
            begin
                comp[0] = unorm_to_byte(a[9:0], 1023);
                comp[1] = unorm_to_byte(a[19:10], 1023);
                comp[2] = unorm_to_byte(a[29:20], 1023);
                comp[3] = 8'(a[31:30] * 85);
            end
            PT_565:
            begin
                comp[0] = unorm_to_byte(a[15:11], 31);
                comp[1] = unorm_to_byte(a[10:5], 63);
                comp[2] = unorm_to_byte(a[4:0], 31);
            end
            PT_24_8:
            begin
                comp[0] = unorm_to_byte(a[31:8], 24'hffffff);
                comp[1] = a[7:0];
            end
            PT_F32_S8:
            begin
                comp[0] = float_to_byte(a);
                comp[1] = b[7:0];
            end
            default:
                for (int i = 0; i < ncomp; i++)
                    comp[i] = comp_to_byte(pt, w[i]);
        endcase
        if (lay == LY_RGBA)
            r = '{comp[2], comp[1], comp[0], comp[3], CNT_BGRA};
        else if (lay == LY_DEP)
            r = '{comp[0], 8'd0, 8'd0, 8'd0, CNT_MONO};
        else
            r = '{comp[0], comp[1], comp[2], 8'd0, CNT_RGBX};
        return r;
    endfunction

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 7))
            0: return 32'd0;
            1: return 32'hffffffff;
            2: return 32'($urandom_range(0, 255));
            3: return {$urandom_range(0, 1) ? 1'b1 : 1'b0, 31'($urandom)};
            4: return {1'($urandom), 8'($urandom_range(100, 130)), 23'($urandom)};
            5: return {1'($urandom), 8'hff, $urandom_range(0, 1) ? 23'd0 : 23'($urandom)};
            6: return 32'($urandom_range(0, 65535)) | {16'($urandom), 16'd0};
            default: return $urandom;
        endcase
    endfunction

    task automatic send_pixel(logic [31:0] a, logic [31:0] b, logic [31:0] c,
                              logic [31:0] d, bit fixed, lanes_t want);
        in_valid <= 1'b1;
        word_a   <= a;
        word_b   <= b;
        word_c   <= c;
        word_d   <= d;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pending_bytes = {pending_bytes, fixed ? want :
                         convert_pixel(cur_ptype, cur_layout, a, b, c, d)};
        @(negedge clk);
        if (!quiet && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending_bytes.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic set_format(logic [3:0] pt, logic [2:0] lay);
        drain();
        cfg_we    <= 1'b1;
        cfg_index <= 1'b0;
        cfg_data  <= pt;
        @(negedge clk);
        cfg_index <= 1'b1;
        cfg_data  <= {1'b0, lay};
        @(negedge clk);
        cfg_we    <= 1'b0;
        cur_ptype  = pt;
        cur_layout = lay;
        @(negedge clk);
    endtask

    initial
    begin
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                out_stall <= 1'b1;
                repeat (60) @(negedge clk);
                hold_req  = 1'b0;
                out_stall <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 5) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 4)) @(negedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        lanes_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_bytes.size() == 0)
            begin
                $error("unexpected result %h %h %h %h count %0d",
                       out_byte0, out_byte1, out_byte2, out_byte3, byte_count);
                errors++;
            end
            else
            begin
                want = pending_bytes.pop_front();
                if (out_byte0 !== want.b0)
                begin
                    $error("out_byte0 expected %h actual %h", want.b0, out_byte0);
                    errors++;
                end
                if (out_byte1 !== want.b1)
                begin
                    $error("out_byte1 expected %h actual %h", want.b1, out_byte1);
                    errors++;
                end
                if (out_byte2 !== want.b2)
                begin
                    $error("out_byte2 expected %h actual %h", want.b2, out_byte2);
                    errors++;
                end
                if (out_byte3 !== want.b3)
                begin
                    $error("out_byte3 expected %h actual %h", want.b3, out_byte3);
                    errors++;
                end
                if (byte_count !== want.cnt)
                begin
                    $error("byte_count expected %0d actual %0d", want.cnt, byte_count);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        #1ms;
        $display("FAIL pixel_to_display_bytes_top");
        $finish;
    end

    initial
    begin
        logic [3:0] pt;
        logic [2:0] lay;
        errors     = 0;
        quiet      = 1'b0;
        hold_req   = 1'b0;
        rst_n      = 1'b0;
        cfg_we     = 1'b0;
        cfg_index  = 1'b0;
        cfg_data   = 4'd0;
        in_valid   = 1'b0;
        word_a     = 32'd0;
        word_b     = 32'd0;
        word_c     = 32'd0;
        word_d     = 32'd0;
        cur_ptype  = PT_U8;
        cur_layout = LY_RGBA;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (pixel_rows[i])
        begin
            if (pixel_rows[i].ptype != cur_ptype || pixel_rows[i].layout != cur_layout)
                set_format(pixel_rows[i].ptype, pixel_rows[i].layout);
            send_pixel(pixel_rows[i].a, pixel_rows[i].b, pixel_rows[i].c,
                       pixel_rows[i].d, pixel_rows[i].fixed, pixel_rows[i].want);
        end

        for (int p = 0; p < 30; p++)
        begin
            pt  = (p < 16) ? 4'(p) : 4'($urandom_range(0, 15));
            lay = (p < 16) ? 3'(p) : 3'($urandom_range(0, 7));
            set_format(pt, lay);
            quiet = (p >= 26);
            for (int n = 0; n < 35; n++)
            begin
                if (p == 5 && n == 2)
                    hold_req = 1'b1;
                if (p == 10 && n == 17)
                    drain();
                send_pixel(pick_word(), pick_word(), pick_word(), pick_word(),
                           1'b0, NO_LANES);
            end
        end

        drain();
        repeat (10) @(negedge clk);
        if (errors == 0 && pending_bytes.size() == 0)
            $display("PASS pixel_to_display_bytes_top");
        else
            $display("FAIL pixel_to_display_bytes_top");
        $finish;
    end
endmodule
`default_nettype wire
